[sv/ecr_pkg.sv]
package ecr_pkg;

    // phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TRIG = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;
    localparam logic [1:0] PH_ECHO = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_RESP   = 2'd1;
    localparam logic [1:0] ST_OUT_RANGE = 2'd2;

    // register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_TRIGGER_TICKS = 2'd0;
    localparam t_cfg_idx CFG_RISE_TIMEOUT  = 2'd1;
    localparam t_cfg_idx CFG_ECHO_TIMEOUT  = 2'd2;
    localparam t_cfg_idx CFG_TICKS_PER_CM  = 2'd3;

    localparam int unsigned CFG_DATA_W = 16;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // register reset values
    localparam logic [7:0]  RST_TRIGGER_TICKS = 8'd20;
    localparam logic [15:0] RST_RISE_TIMEOUT  = 16'd60000;
    localparam logic [15:0] RST_ECHO_TIMEOUT  = 16'd60000;
    localparam logic [7:0]  RST_TICKS_PER_CM  = 8'd116;

    // distance limits
    localparam logic [9:0] CM_SAT       = 10'd998;
    localparam logic [9:0] OUT_RANGE_CM = 10'd999;

    typedef struct packed {
        logic       trigger_level;
        logic       busy_res;
        logic       done_res;
        logic [9:0] distance_cm;
        logic [1:0] status;
    } t_result;

endpackage

[sv/ecr_fsm.sv]
module ecr_fsm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  ecr_pkg::t_cfg_idx  i_cfg_idx,
    input  ecr_pkg::t_cfg_data i_cfg_data,
    input  logic               i_step,
    input  logic               i_start_req,
    input  logic               i_echo_level,
    output ecr_pkg::t_result   o_res
);
    import ecr_pkg::*;

    logic [7:0]  r_trigger_ticks;
    logic [15:0] r_rise_timeout;
    logic [15:0] r_echo_timeout;
    logic [7:0]  r_ticks_per_cm;

    logic [1:0]  r_phase, n_phase;
    logic [15:0] r_pt, n_pt;
    logic [7:0]  r_frac, n_frac;
    logic [9:0]  r_cnt, n_cnt;
    logic [9:0]  r_dist, n_dist;
    logic [1:0]  r_stat, n_stat;
    logic        done;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_ticks <= RST_TRIGGER_TICKS;
            r_rise_timeout  <= RST_RISE_TIMEOUT;
            r_echo_timeout  <= RST_ECHO_TIMEOUT;
            r_ticks_per_cm  <= RST_TICKS_PER_CM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TRIGGER_TICKS: r_trigger_ticks <= i_cfg_data[7:0];
                CFG_RISE_TIMEOUT:  r_rise_timeout  <= i_cfg_data[15:0];
                CFG_ECHO_TIMEOUT:  r_echo_timeout  <= i_cfg_data[15:0];
                CFG_TICKS_PER_CM:  r_ticks_per_cm  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // compute one tick of the measurement sequence
    always_comb begin
        logic        echo_go;
        logic [15:0] pt_base;
        logic [7:0]  frac_base;
        logic [7:0]  frac_inc;
        logic [9:0]  cnt_base;
        n_phase   = r_phase;
        n_pt      = r_pt;
        n_frac    = r_frac;
        n_cnt     = r_cnt;
        n_dist    = r_dist;
        n_stat    = r_stat;
        done      = 1'b0;
        echo_go   = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    n_phase = PH_TRIG;
                    n_pt    = 16'd1;
                    n_frac  = 8'd0;
                    n_cnt   = 10'd0;
                end
            end
            PH_TRIG: begin
                if (r_pt >= {8'd0, r_trigger_ticks}) begin
                    n_phase = PH_WAIT;
                    n_pt    = 16'd0;
                end else begin
                    n_pt = r_pt + 16'd1;
                end
            end
            PH_WAIT: begin
                if (!i_echo_level) begin
                    if (r_pt >= r_rise_timeout) begin
                        n_phase = PH_IDLE;
                        n_pt    = 16'd0;
                        n_stat  = ST_NO_RESP;
                        n_dist  = 10'd0;
                        done    = 1'b1;
                    end else begin
                        n_pt = r_pt + 16'd1;
                    end
                end else begin
                    echo_go = 1'b1;
                end
            end
            PH_ECHO: echo_go = 1'b1;
            default: ;
        endcase

        // count echo ticks; a rise seen in the wait phase starts from zero
        pt_base   = (r_phase == PH_WAIT) ? 16'd0 : r_pt;
        frac_base = (r_phase == PH_WAIT) ? 8'd0  : r_frac;
        cnt_base  = (r_phase == PH_WAIT) ? 10'd0 : r_cnt;
        frac_inc  = frac_base + 8'd1;
        if (echo_go) begin
            n_frac = frac_base;
            n_cnt  = cnt_base;
            if (!i_echo_level) begin
                n_phase = PH_IDLE;
                n_pt    = 16'd0;
                n_stat  = ST_OK;
                n_dist  = cnt_base;
                done    = 1'b1;
            end else if (pt_base >= r_echo_timeout) begin
                n_phase = PH_IDLE;
                n_pt    = 16'd0;
                n_stat  = ST_OUT_RANGE;
                n_dist  = OUT_RANGE_CM;
                done    = 1'b1;
            end else begin
                n_phase = PH_ECHO;
                n_pt    = pt_base + 16'd1;
                if (frac_inc >= r_ticks_per_cm) begin
                    n_frac = 8'd0;
                    if (cnt_base < CM_SAT) begin
                        n_cnt = cnt_base + 10'd1;
                    end
                end else begin
                    n_frac = frac_inc;
                end
            end
        end
    end

    // advance state on each tick taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pt    <= 16'd0;
            r_frac  <= 8'd0;
            r_cnt   <= 10'd0;
            r_dist  <= 10'd0;
            r_stat  <= ST_OK;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pt    <= n_pt;
            r_frac  <= n_frac;
            r_cnt   <= n_cnt;
            r_dist  <= n_dist;
            r_stat  <= n_stat;
        end
    end

    // result word for this tick
    always_comb begin
        o_res.trigger_level = (n_phase == PH_TRIG);
        o_res.busy_res      = (n_phase != PH_IDLE);
        o_res.done_res      = done;
        o_res.distance_cm   = n_dist;
        o_res.status        = n_stat;
    end

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.done_res) |=> (r_phase == PH_IDLE))
        else $error("finished measurement did not return to idle");
    a_ok_not_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stat == ST_OK) |-> (r_dist != OUT_RANGE_CM))
        else $error("ok status with out-of-range distance");
    a_start_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == PH_IDLE && i_start_req) |=> (r_phase == PH_TRIG))
        else $error("start request in idle did not launch trigger");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_phase) && $stable(r_pt) && $stable(r_dist)))
        else $error("state moved without a tick");
`endif

endmodule

[sv/ecr_obuf.sv]
module ecr_obuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ecr_pkg::t_result i_res,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_stall,
    output ecr_pkg::t_result o_res
);
    import ecr_pkg::*;

    t_result    r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       pop, push;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_mem[r_rp];
    assign pop     = o_valid && !i_stall;
    assign push    = i_push && !o_full;

    // store result words
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_res;
        end
    end

    // track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer overfilled");
    a_full_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 || r_cnt == 2'd0) |-> (r_wp == r_rp))
        else $error("buffer pointers out of step with fill level");
    a_keep_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_res)))
        else $error("stalled word lost or changed");
`endif

endmodule

[sv/ultrasonic_echo_ranger_core.sv]
// Ultrasonic echo ranger core.
// Input channel (i_valid / o_stall): one word per 0.5 us timer tick, carrying
// the start request and the sampled echo level. Output channel (o_valid /
// i_stall): one result word per tick with the trigger level to drive, busy,
// done, and the last finished distance and status.
// Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is
// high (0 trigger ticks, 1 rise timeout, 2 echo timeout, 3 ticks per cm).
// Write only while no tick is in flight.
// Path: a tick taken sits in the input register; once the output buffer has
// room, its result enters the two-word output buffer and is offered behind any
// older word still held there.
// Throughput: one tick per cycle while the output buffer has room; the step
// logic is a single pass of counters and compares from input register to buffer.
// Stall: while the receiver stalls, the output buffer fills; once both words
// are held, the input register holds its tick and o_stall rises.
// Reset: i_rst_n low for one edge returns to idle, loads the default register
// values and empties the buffer; distance and status read 0 until the first
// measurement finishes.
module ultrasonic_echo_ranger_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  ecr_pkg::t_cfg_idx  i_cfg_idx,
    input  ecr_pkg::t_cfg_data i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_start_req,
    input  logic               i_echo_level,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_trigger_level,
    output logic               o_busy_res,
    output logic               o_done_res,
    output logic [9:0]         o_distance_cm,
    output logic [1:0]         o_status
);
    import ecr_pkg::*;

    logic    r_in_valid;
    logic    r_start_req;
    logic    r_echo_level;
    logic    buf_full;
    logic    step;
    logic    accept;
    t_result step_res;
    t_result out_res;

    assign step    = r_in_valid && !buf_full;
    assign o_stall = r_in_valid && buf_full;
    assign accept  = i_valid && !o_stall;

    // hold the accepted tick word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_start_req  <= i_start_req;
            r_echo_level <= i_echo_level;
        end
    end

    ecr_fsm u_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_step       (step),
        .i_start_req  (r_start_req),
        .i_echo_level (r_echo_level),
        .o_res        (step_res)
    );

    ecr_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_res   (step_res),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (out_res)
    );

    // drive result fields
    assign o_trigger_level = out_res.trigger_level;
    assign o_busy_res      = out_res.busy_res;
    assign o_done_res      = out_res.done_res;
    assign o_distance_cm   = out_res.distance_cm;
    assign o_status        = out_res.status;

endmodule

[tb/testbench.sv]
module testbench;
    import ecr_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_WORDS = 400;
    localparam int RANDOM_SETS  = 8;
    localparam int REPORT_MAX   = 10;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;
    typedef enum logic {ROW_TICK, ROW_CFG} t_row_kind;

    // one line of the directed table: a run of equal ticks or a register write
    typedef struct {
        t_row_kind kind;
        logic      start;
        logic      echo;
        int        reps;
        logic      chk;
        t_result   res;
        t_cfg_idx  idx;
        t_cfg_data data;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    t_cfg_idx   i_cfg_idx = CFG_TRIGGER_TICKS;
    t_cfg_data  i_cfg_data = '0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic       i_start_req = 1'b0;
    logic       i_echo_level = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_trigger_level;
    logic       o_busy_res;
    logic       o_done_res;
    logic [9:0] o_distance_cm;
    logic [1:0] o_status;

    ultrasonic_echo_ranger_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_start_req     (i_start_req),
        .i_echo_level    (i_echo_level),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_trigger_level (o_trigger_level),
        .o_busy_res      (o_busy_res),
        .o_done_res      (o_done_res),
        .o_distance_cm   (o_distance_cm),
        .o_status        (o_status)
    );

    always #1 i_clk = ~i_clk;

    // ranger state and register copies
    logic [1:0]  ph = PH_IDLE;
    logic [15:0] ph_ticks = '0;
    logic [7:0]  cm_frac = '0;
    logic [9:0]  cm_cnt = '0;
    logic [9:0]  last_dist = '0;
    logic [1:0]  last_st = ST_OK;
    logic [7:0]  cfg_trig = RST_TRIGGER_TICKS;
    logic [15:0] cfg_rise = RST_RISE_TIMEOUT;
    logic [15:0] cfg_echo = RST_ECHO_TIMEOUT;
    logic [7:0]  cfg_tpcm = RST_TICKS_PER_CM;

    t_result    pending_results[$];
    t_row       dir_rows[$];
    t_idle_mode idle_mode = IDLE_NONE;
    logic       typed_on = 1'b0;
    t_result    typed_res = '0;

    int words_in = 0;
    int words_out = 0;
    int words_sent = 0;
    int errors = 0;
    int stall_cycles = 0;
    int n_ok = 0;
    int n_none = 0;
    int n_far = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int cycle_count = 0;

    function automatic t_result mk_res(input logic trig, input logic busy, input logic done,
                                       input logic [9:0] dist_cm, input logic [1:0] st);
        t_result r;
        r = {trig, busy, done, dist_cm, st};
        return r;
    endfunction

    function automatic int send_idle_pct();
        case (idle_mode)
            IDLE_SEND: return 73;
            IDLE_BOTH: return 7;
            default:   return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct();
        case (idle_mode)
            IDLE_RECV: return 73;
            IDLE_BOTH: return 7;
            default:   return 0;
        endcase
    endfunction

    // end a measurement and latch its result
    task automatic close_measure(input logic [1:0] st, input logic [9:0] dist_cm,
                                 output logic done);
        ph = PH_IDLE;
        ph_ticks = '0;
        last_st = st;
        last_dist = dist_cm;
        done = 1'b1;
        case (st)
            ST_OK:      n_ok++;
            ST_NO_RESP: n_none++;
            default:    n_far++;
        endcase
    endtask

    // advance the ranger by one tick and form its result word
    task automatic advance_ranger(input logic start, input logic echo, output t_result r);
        logic done;
        done = 1'b0;
        case (ph)
            PH_IDLE: begin
                if (start) begin
                    ph = PH_TRIG;
                    ph_ticks = 16'd1;
                    cm_frac = '0;
                    cm_cnt = '0;
                end
            end
            PH_TRIG: begin
                if (ph_ticks >= {8'd0, cfg_trig}) begin
                    ph = PH_WAIT;
                    ph_ticks = '0;
                end else begin
                    ph_ticks = ph_ticks + 16'd1;
                end
            end
            default: begin
                if (ph == PH_WAIT) begin
                    if (!echo) begin
                        if (ph_ticks >= cfg_rise) close_measure(ST_NO_RESP, 10'd0, done);
                        else ph_ticks = ph_ticks + 16'd1;
                    end else begin
                        ph = PH_ECHO;
                        ph_ticks = '0;
                        cm_frac = '0;
                        cm_cnt = '0;
                    end
                end
                if (ph == PH_ECHO) begin
                    if (!echo) begin
                        close_measure(ST_OK, cm_cnt, done);
                    end else if (ph_ticks >= cfg_echo) begin
                        close_measure(ST_OUT_RANGE, OUT_RANGE_CM, done);
                    end else begin
                        ph_ticks = ph_ticks + 16'd1;
                        cm_frac = cm_frac + 8'd1;
                        if (cm_frac >= cfg_tpcm) begin
                            cm_frac = '0;
                            if (cm_cnt < CM_SAT) cm_cnt = cm_cnt + 10'd1;
                        end
                    end
                end
            end
        endcase
        r = mk_res(ph == PH_TRIG, ph != PH_IDLE, done, last_dist, last_st);
    endtask

    task automatic note_mismatch(input string tag, input t_result want, input t_result got);
        if (errors < REPORT_MAX) begin
            $write("%s at word %0d: expected trig %0b busy %0b done %0b dist %0d st %0d,",
                   tag, words_out, want.trigger_level, want.busy_res, want.done_res,
                   want.distance_cm, want.status);
            $display(" got trig %0b busy %0b done %0b dist %0d st %0d",
                     got.trigger_level, got.busy_res, got.done_res, got.distance_cm,
                     got.status);
        end
        errors++;
    endtask

    // predict on accepted input words, check accepted result words
    always @(posedge i_clk) begin
        t_result predicted;
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (i_valid && o_stall) stall_cycles++;
            if (i_valid && !o_stall) begin
                advance_ranger(i_start_req, i_echo_level, predicted);
                pending_results.push_back(typed_on ? typed_res : predicted);
                words_in++;
            end
            if (o_valid && !i_stall) begin
                got = {o_trigger_level, o_busy_res, o_done_res, o_distance_cm, o_status};
                words_out++;
                if (pending_results.size() == 0) begin
                    note_mismatch("unexpected word", '0, got);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) note_mismatch("mismatch", want, got);
                end
            end
        end
    end

    // receiver: random stall, or a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct());
        end
    end

    // watchdog
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench failed");
        $finish;
    end

    // offer one word and hold it until taken
    task automatic send_word(input logic start, input logic echo, input logic chk,
                             input t_result res);
        int seen;
        while ($urandom_range(0, 99) < send_idle_pct()) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_start_req <= start;
        i_echo_level <= echo;
        typed_on <= chk;
        typed_res <= res;
        seen = words_in;
        @(negedge i_clk);
        while (words_in == seen) @(negedge i_clk);
        words_sent++;
    endtask

    task automatic send_tick(input logic start, input logic echo);
        send_word(start, echo, 1'b0, '0);
    endtask

    // drop valid and wait until every result has come back
    task automatic drain_words();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_TRIGGER_TICKS: cfg_trig = val[7:0];
            CFG_RISE_TIMEOUT:  cfg_rise = val;
            CFG_ECHO_TIMEOUT:  cfg_echo = val;
            default:           cfg_tpcm = val[7:0];
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // finish any open measurement with a short echo
    task automatic flush_measure();
        while (ph != PH_IDLE) send_tick(1'b0, ph == PH_WAIT);
    endtask

    // one well-formed measurement with random timing
    task automatic run_measure();
        int n_low;
        int n_high;
        send_tick(1'b1, $urandom_range(0, 1));
        while (ph == PH_TRIG) send_tick($urandom_range(0, 1), $urandom_range(0, 1));
        n_low = $urandom_range(0, cfg_rise + 1);
        repeat (n_low) send_tick($urandom_range(0, 15) == 0, 1'b0);
        if (ph == PH_WAIT) begin
            if ($urandom_range(0, 3) != 0) n_high = $urandom_range(1, cfg_echo);
            else n_high = cfg_echo + $urandom_range(1, 3);
            repeat (n_high) send_tick($urandom_range(0, 15) == 0, 1'b1);
            send_tick($urandom_range(0, 7) == 0, 1'b0);
        end
    endtask

    task automatic add_tick(input logic start, input logic echo, input int reps);
        t_row r;
        r = '{ROW_TICK, start, echo, reps, 1'b0, '0, CFG_TRIGGER_TICKS, '0};
        dir_rows.push_back(r);
    endtask

    task automatic add_check(input logic start, input logic echo, input int reps,
                             input t_result res);
        t_row r;
        r = '{ROW_TICK, start, echo, reps, 1'b1, res, CFG_TRIGGER_TICKS, '0};
        dir_rows.push_back(r);
    endtask

    task automatic add_cfg(input t_cfg_idx idx, input t_cfg_data data);
        t_row r;
        r = '{ROW_CFG, 1'b0, 1'b0, 0, 1'b0, '0, idx, data};
        dir_rows.push_back(r);
    endtask

    initial begin
        int goal;

        // defaults: trigger 20, timeouts 60000, 116 ticks per cm
        add_check(1'b0, 1'b0, 3, mk_res(1'b0, 1'b0, 1'b0, 10'd0, ST_OK));
        add_check(1'b0, 1'b1, 2, mk_res(1'b0, 1'b0, 1'b0, 10'd0, ST_OK));
        add_check(1'b1, 1'b0, 1, mk_res(1'b1, 1'b1, 1'b0, 10'd0, ST_OK));
        // start ignored while busy, echo not looked at during trigger
        add_check(1'b1, 1'b1, 19, mk_res(1'b1, 1'b1, 1'b0, 10'd0, ST_OK));
        add_check(1'b0, 1'b1, 1, mk_res(1'b0, 1'b1, 1'b0, 10'd0, ST_OK));
        add_tick(1'b0, 1'b0, 4);
        add_check(1'b0, 1'b1, 353, mk_res(1'b0, 1'b1, 1'b0, 10'd0, ST_OK));
        // fall with a start on the same tick: start dropped
        add_check(1'b1, 1'b0, 1, mk_res(1'b0, 1'b0, 1'b1, 10'd3, ST_OK));
        add_check(1'b0, 1'b0, 2, mk_res(1'b0, 1'b0, 1'b0, 10'd3, ST_OK));
        // all zero registers: one-tick trigger, immediate timeouts
        add_cfg(CFG_TRIGGER_TICKS, 16'd0);
        add_cfg(CFG_RISE_TIMEOUT, 16'd0);
        add_cfg(CFG_ECHO_TIMEOUT, 16'd0);
        add_cfg(CFG_TICKS_PER_CM, 16'd0);
        add_check(1'b1, 1'b0, 1, mk_res(1'b1, 1'b1, 1'b0, 10'd3, ST_OK));
        add_check(1'b0, 1'b0, 1, mk_res(1'b0, 1'b1, 1'b0, 10'd3, ST_OK));
        add_check(1'b0, 1'b0, 1, mk_res(1'b0, 1'b0, 1'b1, 10'd0, ST_NO_RESP));
        add_tick(1'b1, 1'b1, 2);
        add_check(1'b0, 1'b1, 1, mk_res(1'b0, 1'b0, 1'b1, OUT_RANGE_CM, ST_OUT_RANGE));
        // long echo: count saturates below the out-of-range code
        add_cfg(CFG_ECHO_TIMEOUT, 16'hFFFF);
        add_tick(1'b1, 1'b0, 2);
        add_tick(1'b0, 1'b1, 1000);
        add_check(1'b0, 1'b0, 1, mk_res(1'b0, 1'b0, 1'b1, CM_SAT, ST_OK));
        // upper data bits masked off: trigger 3, two ticks per cm
        add_cfg(CFG_TRIGGER_TICKS, 16'hAB03);
        add_cfg(CFG_TICKS_PER_CM, 16'h1202);
        add_cfg(CFG_RISE_TIMEOUT, 16'hFFFF);
        add_tick(1'b1, 1'b0, 1);
        add_tick(1'b0, 1'b0, 8);
        add_tick(1'b0, 1'b1, 9);
        add_check(1'b0, 1'b0, 1, mk_res(1'b0, 1'b0, 1'b1, 10'd4, ST_OK));
        // short timeouts hit exactly
        add_cfg(CFG_TRIGGER_TICKS, 16'd2);
        add_cfg(CFG_RISE_TIMEOUT, 16'd3);
        add_cfg(CFG_ECHO_TIMEOUT, 16'd10);
        add_cfg(CFG_TICKS_PER_CM, 16'd3);
        add_tick(1'b1, 1'b0, 1);
        add_tick(1'b0, 1'b0, 10);
        add_tick(1'b1, 1'b0, 1);
        add_tick(1'b0, 1'b0, 3);
        add_tick(1'b0, 1'b1, 12);

        // hold reset, then release it on a falling edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // walk the directed table
        idle_mode = IDLE_BOTH;
        for (int r = 0; r < dir_rows.size(); r++) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                drain_words();
                write_reg(dir_rows[r].idx, dir_rows[r].data);
            end else begin
                for (int k = 0; k < dir_rows[r].reps; k++)
                    send_word(dir_rows[r].start, dir_rows[r].echo,
                              dir_rows[r].chk && (k == dir_rows[r].reps - 1), dir_rows[r].res);
            end
        end
        flush_measure();
        drain_words();

        // random sets, each with its own registers and idling pattern
        for (int p = 0; p < RANDOM_SETS; p++) begin
            idle_mode = t_idle_mode'(p % 4);
            write_reg(CFG_TRIGGER_TICKS, {8'($urandom_range(0, 255)), 8'($urandom_range(0, 6))});
            write_reg(CFG_RISE_TIMEOUT, 16'($urandom_range(0, 24)));
            write_reg(CFG_ECHO_TIMEOUT, 16'($urandom_range(0, 90)));
            write_reg(CFG_TICKS_PER_CM, {8'($urandom_range(0, 255)), 8'($urandom_range(0, 12))});
            // back-pressure: long receiver hold-off while words keep coming
            if (p == 0) hold_req++;
            goal = words_sent + RANDOM_WORDS / RANDOM_SETS;
            while (words_sent < goal) begin
                if (ph != PH_IDLE) flush_measure();
                if ($urandom_range(0, 4) != 0) run_measure();
                else repeat ($urandom_range(1, 6)) send_tick($urandom_range(0, 1),
                                                             $urandom_range(0, 1));
            end
            flush_measure();
            drain_words();
        end

        repeat (8) @(negedge i_clk);
        $display("%0d tick words checked over directed and %0d random register sets",
                 words_out, RANDOM_SETS);
        $display("measurements: %0d ok, %0d no response, %0d out of range; %0d stall cycles",
                 n_ok, n_none, n_far, stall_cycles);
        if (errors == 0) $display("testbench passed");
        else $display("testbench failed");
        $finish;
    end

endmodule
